### hdl/reversible_deque_core_assert.svh
// Assertion macros shared by the deque core.
`ifndef REVERSIBLE_DEQUE_CORE_ASSERT_SVH
`define REVERSIBLE_DEQUE_CORE_ASSERT_SVH

// Condition must hold in the same cycle as the trigger.
`define RDQ_ASSERT_SAME(lbl, clk, rst_n, trig, cond) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (trig) |-> (cond)) \
        else $error("deque check failed: same-cycle rule");

// Condition must hold in the cycle after the trigger.
`define RDQ_ASSERT_NEXT(lbl, clk, rst_n, trig, cond) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (trig) |=> (cond)) \
        else $error("deque check failed: next-cycle rule");

`endif

### hdl/rdq_pkg.sv
package rdq_pkg;

    // Store geometry
    localparam int DEPTH  = 1024;
    localparam int ADDR_W = $clog2(DEPTH);
    localparam int CNT_W  = $clog2(DEPTH + 1);
    localparam int SUM_W  = CNT_W + 1;
    localparam int WORD_W = 32;

    typedef enum logic [2:0] {
        ACT_PUSH_FRONT = 3'd0,
        ACT_PUSH_BACK  = 3'd1,
        ACT_POP_FRONT  = 3'd2,
        ACT_POP_BACK   = 3'd3,
        ACT_REVERSE    = 3'd4
    } t_action;

    typedef enum logic [1:0] {
        ST_POPPED = 2'd0,
        ST_EMPTY  = 2'd1,
        ST_FULL   = 2'd2
    } t_status;

    typedef enum logic [1:0] {
        S_RESET = 2'd0,
        S_IDLE  = 2'd1,
        S_EMIT  = 2'd2
    } t_state;

    // Commands from controller to datapath
    typedef struct packed {
        logic mem_wr;
        logic mem_rd;
        logic phys_front;
        logic push;
        logic pop;
        logic flip;
    } t_dp_cmd;

    // Status from datapath to controller
    typedef struct packed {
        logic empty;
        logic full;
        logic reversed;
    } t_dp_stat;

endpackage

### hdl/rdq_dp.sv
module rdq_dp import rdq_pkg::*; (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  t_dp_cmd                  i_cmd,
    input  logic signed [WORD_W-1:0] i_value,
    output t_dp_stat                 o_stat,
    output logic signed [WORD_W-1:0] o_word
);

    logic [ADDR_W-1:0] r_head;
    logic [ADDR_W-1:0] n_head;
    logic [CNT_W-1:0]  r_count;
    logic [CNT_W-1:0]  n_count;
    logic              r_reversed;
    logic              r_word_sel;
    logic [WORD_W-1:0] r_rd_data;
    logic [WORD_W-1:0] r_mem [DEPTH];

    logic [ADDR_W-1:0] head_dec;
    logic [ADDR_W-1:0] head_inc;
    logic [CNT_W-1:0]  back_off;
    logic [SUM_W-1:0]  back_sum;
    logic [ADDR_W-1:0] back_slot;
    logic [ADDR_W-1:0] addr;

    // Neighbors of the physical front, with wrap
    assign head_dec = (r_head == '0) ? ADDR_W'(DEPTH - 1) : r_head - 1'b1;
    assign head_inc = (r_head == ADDR_W'(DEPTH - 1)) ? '0 : r_head + 1'b1;

    // Physical back slot: first free slot for push, last used slot for pop
    assign back_off = i_cmd.pop ? r_count - 1'b1 : r_count;
    assign back_sum = SUM_W'(r_head) + SUM_W'(back_off);
    assign back_slot = (back_sum >= SUM_W'(DEPTH)) ? ADDR_W'(back_sum - SUM_W'(DEPTH))
                                                   : ADDR_W'(back_sum);

    // Select the one store address this beat touches
    assign addr = i_cmd.phys_front ? (i_cmd.push ? head_dec : r_head) : back_slot;

    // Advance head and count
    always_comb begin
        n_head  = r_head;
        n_count = r_count;
        if (i_cmd.push) begin
            n_count = r_count + 1'b1;
            if (i_cmd.phys_front) begin
                n_head = head_dec;
            end
        end else if (i_cmd.pop) begin
            n_count = r_count - 1'b1;
            if (i_cmd.phys_front) begin
                n_head = head_inc;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head     <= '0;
            r_count    <= '0;
            r_reversed <= 1'b0;
        end else begin
            r_head     <= n_head;
            r_count    <= n_count;
            r_reversed <= r_reversed ^ i_cmd.flip;
        end
    end

    // Store: one write or one registered read per cycle
    always_ff @(posedge i_clk) begin
        if (i_cmd.mem_wr) begin
            r_mem[addr] <= i_value;
        end
        if (i_cmd.mem_rd) begin
            r_rd_data <= r_mem[addr];
        end
        r_word_sel <= i_cmd.pop;
    end

    assign o_stat.empty    = (r_count == '0);
    assign o_stat.full     = (r_count == CNT_W'(DEPTH));
    assign o_stat.reversed = r_reversed;

    // Drop the word to zero unless this result is a successful pop
    assign o_word = r_word_sel ? r_rd_data : '0;

endmodule

### hdl/rdq_ctrl.sv
module rdq_ctrl import rdq_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_start,
    input  logic [2:0] i_action,
    input  t_dp_stat   i_stat,
    output t_dp_cmd    o_cmd,
    output logic       o_busy,
    output logic       o_valid,
    output logic [1:0] o_status
);

    t_state  r_state;
    t_state  n_state;
    t_status r_status;
    t_status n_status;
    logic    accept;
    logic    emit;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_RESET;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        r_status <= n_status;
    end

    // Decode the beat, issue datapath commands, pick the next state
    always_comb begin
        accept   = i_start && (r_state != S_RESET);
        emit     = 1'b0;
        n_status = r_status;
        o_cmd    = '0;
        if (accept) begin
            case (t_action'(i_action))
                ACT_PUSH_FRONT, ACT_PUSH_BACK: begin
                    if (i_stat.full) begin
                        emit     = 1'b1;
                        n_status = ST_FULL;
                    end else begin
                        o_cmd.push       = 1'b1;
                        o_cmd.mem_wr     = 1'b1;
                        o_cmd.phys_front = (i_action == ACT_PUSH_FRONT) ^ i_stat.reversed;
                    end
                end
                ACT_POP_FRONT, ACT_POP_BACK: begin
                    emit = 1'b1;
                    if (i_stat.empty) begin
                        n_status = ST_EMPTY;
                    end else begin
                        n_status         = ST_POPPED;
                        o_cmd.pop        = 1'b1;
                        o_cmd.mem_rd     = 1'b1;
                        o_cmd.phys_front = (i_action == ACT_POP_FRONT) ^ i_stat.reversed;
                    end
                end
                ACT_REVERSE: begin
                    o_cmd.flip = 1'b1;
                end
                default: begin
                    emit = 1'b0;
                end
            endcase
        end
        case (r_state)
            S_RESET: n_state = S_IDLE;
            S_IDLE,
            S_EMIT:  n_state = emit ? S_EMIT : S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    assign o_busy   = (r_state == S_RESET);
    assign o_valid  = (r_state == S_EMIT);
    assign o_status = r_status;

endmodule

### hdl/reversible_deque_core.sv
// Bounded double-ended queue of 1024 signed 32-bit words with a constant-time
// reverse. One command is taken per clock whenever o_busy is low; o_busy is
// high while reset is held and until the FSM leaves S_RESET. Pops, pushes into
// a full queue and pops from an empty queue each return one result, strobed
// by o_valid for a single cycle, in the cycle after the command was accepted;
// the receiver cannot stall, so it must take every result as it appears.
// Successful pushes, reverse and unused action codes return nothing. The result
// is registered; the popped word comes from the store's registered read port.
module reversible_deque_core import rdq_pkg::*; (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_start,
    input  logic [2:0]               i_action,
    input  logic signed [WORD_W-1:0] i_value,
    output logic                     o_busy,
    output logic                     o_valid,
    output logic [1:0]               o_status,
    output logic signed [WORD_W-1:0] o_word
);

    `include "reversible_deque_core_assert.svh"

    t_dp_cmd  cmd;
    t_dp_stat stat;

    rdq_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (i_start),
        .i_action (i_action),
        .i_stat   (stat),
        .o_cmd    (cmd),
        .o_busy   (o_busy),
        .o_valid  (o_valid),
        .o_status (o_status)
    );

    rdq_dp u_dp (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (cmd),
        .i_value (i_value),
        .o_stat  (stat),
        .o_word  (o_word)
    );

    // Never write into a full store or read from an empty one
    `RDQ_ASSERT_SAME(a_push_not_full, i_clk, i_rst_n, cmd.push, !stat.full)
    `RDQ_ASSERT_SAME(a_pop_not_empty, i_clk, i_rst_n, cmd.pop, !stat.empty)
    // A real pop yields a popped-word result on the next cycle
    `RDQ_ASSERT_NEXT(a_pop_result, i_clk, i_rst_n, cmd.pop,
        o_valid && (o_status == ST_POPPED))
    // A push always leaves something stored
    `RDQ_ASSERT_NEXT(a_push_fills, i_clk, i_rst_n, cmd.push, !stat.empty)

endmodule
